[sv/dvrt_pkg.sv]
// Shared types and constants for the distance-vector route table.
`timescale 1ns / 1ps
`default_nettype none
package dvrt_pkg;
  localparam int CW = 24;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_CHG   = 3'd1,
    OP_ADV   = 3'd2,
    OP_HEARD = 3'd3,
    OP_CHECK = 3'd4,
    OP_DUMP  = 3'd5,
    OP_NOP6  = 3'd6,
    OP_NOP7  = 3'd7
  } op_t;

  localparam logic REG_MY_NODE = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;
endpackage
`default_nettype wire

[sv/dvrt_alu.sv]
// Shared cost unit: x - y + z, floored at zero and saturated at infinity.
`timescale 1ns / 1ps
`default_nettype none
module dvrt_alu import dvrt_pkg::*; #(
  parameter int COST_INF = 10000000
) (
  input  wire logic [CW-1:0] x,
  input  wire logic [CW-1:0] y,
  input  wire logic [CW-1:0] z,
  output logic      [CW-1:0] res
);
  logic signed [CW+1:0] s;

  always_comb begin
    s = $signed({2'b00, x}) - $signed({2'b00, y}) + $signed({2'b00, z});
    if (s[CW+1]) begin
      res = '0;
    end else if (s > $signed((CW+2)'(COST_INF))) begin
      res = CW'(COST_INF);
    end else begin
      res = s[CW-1:0];
    end
  end
endmodule
`default_nettype wire

[sv/distance_vector_route_table_core.sv]
// Distance-vector route table: sequencer, tables and result register.
//
//  channel | signals                                   | role
//  in      | in_valid in_ready opcode node_a node_b cost now | opcode items
//  out     | out_valid out_ready dest next_node route_cost present link_up links_down last
//  cfg     | cfg_we cfg_index cfg_data                 | my_node, down_timeout
//
// Change cost and check step one table entry a cycle through their passes;
// change cost and advert use the shared cost unit, dump returns one entry per
// result taken. One item at a time: in_ready is low until the last
// result is taken. Reset clears flags and state; tables hold no reset.
`timescale 1ns / 1ps
`default_nettype none
module distance_vector_route_table_core import dvrt_pkg::*; #(
  parameter int NODES      = 16,
  parameter int COST_INF   = 10000000,
  parameter int CLOCK_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    opcode,
  input  wire logic [3:0]    node_a,
  input  wire logic [3:0]    node_b,
  input  wire logic [CW-1:0] cost,
  input  wire logic [15:0]   now,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [3:0]         dest,
  output logic [4:0]         next_node,
  output logic [CW-1:0]      route_cost,
  output logic               present,
  output logic               link_up,
  output logic [4:0]         links_down,
  output logic               last,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [7:0]    cfg_data
);
  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int HW = $clog2(NODES + 1);
  localparam int DUMP_N = (NODES < 16) ? NODES : 16;
  localparam logic [HW-1:0] NO_HOP = HW'(NODES);
  localparam logic [CW-1:0] INF = CW'(COST_INF);
  localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);
  localparam logic [IW-1:0] LAST_DUMP = IW'(DUMP_N - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_ADD2, S_ADV, S_CHG, S_CHK1, S_CHK2, S_DUMP, S_RESP
  } state_t;

  state_t state;
  logic [3:0] my_node;
  logic [7:0] down_timeout;
  op_t op_r;
  logic [IW-1:0] a_r, b_r, idx;
  logic a_ok, b_ok;
  logic [CW-1:0] cost_r, prev, through;
  logic [CLOCK_BITS-1:0] now_r;
  logic [HW-1:0] down_cnt;
  logic up_r;
  logic [NODES-1:0] mask, rt_pres, is_nb, heard, down_f;

  logic [HW-1:0] rt_hop [NODES];
  logic [CW-1:0] rt_met [NODES];
  logic [CW-1:0] nc_mem [NODES];
  logic [CLOCK_BITS-1:0] lh_mem [NODES];
  logic [CW-1:0] sc_mem [NODES];

  logic rt_we, nc_we, lh_we, sc_we;
  logic [HW-1:0] rt_hop_wd;
  logic [CW-1:0] rt_met_wd;
  logic [CW-1:0] ncur, cur_met, eff_met, alu_x, alu_y, alu_res, cost_c;
  logic [HW-1:0] cur_hop, eff_hop;
  logic [CLOCK_BITS-1:0] elapsed;
  logic a_is_my, b_is_my, timed_out, hop_masked;

  assign cost_c = (cost > INF) ? INF : cost;
  assign ncur = is_nb[idx] ? nc_mem[idx] : '0;
  assign cur_hop = rt_hop[idx];
  assign cur_met = rt_met[idx];
  assign eff_hop = rt_pres[idx] ? cur_hop : NO_HOP;
  assign eff_met = rt_pres[idx] ? cur_met : INF;
  assign a_is_my = (32'(a_r) == 32'(my_node));
  assign b_is_my = (32'(b_r) == 32'(my_node));
  assign elapsed = now_r - lh_mem[idx];
  assign timed_out = (32'(elapsed) >= 32'(down_timeout));
  assign hop_masked = (32'(cur_hop) < NODES) && mask[cur_hop[IW-1:0]];

  assign alu_x = (state == S_CHG) ? cur_met : ncur;
  assign alu_y = (state == S_CHG) ? prev : '0;

  dvrt_alu #(.COST_INF(COST_INF)) u_alu (
    .x(alu_x), .y(alu_y), .z(cost_r), .res(alu_res)
  );

  always_comb begin
    rt_we = 1'b0;
    rt_hop_wd = NO_HOP;
    rt_met_wd = INF;
    nc_we = 1'b0;
    lh_we = 1'b0;
    sc_we = 1'b0;
    case (state)
      S_EXEC: begin
        case (op_r)
          OP_ADD: begin
            if (a_ok && b_ok) begin
              if (a_is_my || b_is_my) begin
                nc_we = 1'b1;
                rt_we = 1'b1;
                rt_hop_wd = HW'(idx);
                rt_met_wd = cost_r;
              end else begin
                rt_we = !is_nb[idx];
              end
            end
          end
          OP_CHG: nc_we = a_ok;
          OP_HEARD: begin
            lh_we = a_ok;
            if (a_ok && down_f[idx]) begin
              rt_we = 1'b1;
              rt_hop_wd = HW'(idx);
              rt_met_wd = sc_mem[idx];
            end
          end
          default: ;
        endcase
      end
      S_ADD2: rt_we = !is_nb[idx];
      S_ADV: begin
        if (((through < eff_met) && !b_is_my) || (eff_hop == HW'(a_r))) begin
          rt_we = 1'b1;
          rt_hop_wd = HW'(a_r);
          rt_met_wd = through;
        end
      end
      S_CHG: begin
        if (rt_pres[idx] && cur_hop == HW'(a_r) && cur_met < INF) begin
          rt_we = 1'b1;
          rt_hop_wd = cur_hop;
          rt_met_wd = alu_res;
        end
      end
      S_CHK1: sc_we = heard[idx] && !down_f[idx] && timed_out;
      S_CHK2: rt_we = rt_pres[idx] && hop_masked;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rt_we) begin
      rt_hop[idx] <= rt_hop_wd;
      rt_met[idx] <= rt_met_wd;
    end
    if (nc_we) nc_mem[idx] <= cost_r;
    if (lh_we) lh_mem[idx] <= now_r;
    if (sc_we) sc_mem[idx] <= ncur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      my_node <= '0;
      down_timeout <= 8'd3;
      rt_pres <= '0;
      is_nb <= '0;
      heard <= '0;
      down_f <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MY_NODE: my_node <= cfg_data[3:0];
          REG_TIMEOUT: down_timeout <= cfg_data;
          default: ;
        endcase
      end
      if (rt_we) rt_pres[idx] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= op_t'(opcode);
            a_r <= IW'(node_a);
            b_r <= IW'(node_b);
            a_ok <= (32'(node_a) < NODES);
            b_ok <= (32'(node_b) < NODES);
            cost_r <= cost_c;
            now_r <= CLOCK_BITS'(now);
            up_r <= 1'b0;
            down_cnt <= '0;
            mask <= '0;
            dest <= '0;
            next_node <= 5'(NO_HOP);
            route_cost <= '0;
            present <= 1'b0;
            last <= 1'b1;
            if (op_t'(opcode) == OP_ADD && node_a == my_node) idx <= IW'(node_b);
            else if (opcode == OP_ADD || opcode == OP_CHG || opcode == OP_ADV ||
                     opcode == OP_HEARD) idx <= IW'(node_a);
            else idx <= '0;
            if (opcode == OP_DUMP) state <= S_DUMP;
            else if (opcode == OP_CHECK) state <= S_CHK1;
            else state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_RESP;
          out_valid <= 1'b1;
          case (op_r)
            OP_ADD: begin
              if (a_ok && b_ok) begin
                if (a_is_my || b_is_my) begin
                  is_nb[idx] <= 1'b1;
                end else begin
                  idx <= b_r;
                  state <= S_ADD2;
                  out_valid <= 1'b0;
                end
              end
            end
            OP_CHG: begin
              if (a_ok) begin
                prev <= ncur;
                is_nb[idx] <= 1'b1;
                idx <= '0;
                state <= S_CHG;
                out_valid <= 1'b0;
              end
            end
            OP_ADV: begin
              if (a_ok && b_ok) begin
                through <= alu_res;
                idx <= b_r;
                state <= S_ADV;
                out_valid <= 1'b0;
              end
            end
            OP_HEARD: begin
              if (a_ok) begin
                heard[idx] <= 1'b1;
                if (down_f[idx]) begin
                  down_f[idx] <= 1'b0;
                  up_r <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        S_ADD2, S_ADV: begin
          state <= S_RESP;
          out_valid <= 1'b1;
        end
        S_CHG: begin
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= S_RESP;
            out_valid <= 1'b1;
          end
        end
        S_CHK1: begin
          if (sc_we) begin
            down_f[idx] <= 1'b1;
            mask[idx] <= 1'b1;
            down_cnt <= down_cnt + 1'b1;
          end
          if (idx == LAST_IDX) begin
            idx <= '0;
            state <= S_CHK2;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CHK2: begin
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= S_RESP;
            out_valid <= 1'b1;
          end
        end
        S_DUMP: begin
          dest <= 4'(idx);
          next_node <= 5'(eff_hop);
          route_cost <= eff_met;
          present <= rt_pres[idx];
          last <= (idx == LAST_DUMP);
          state <= S_RESP;
          out_valid <= 1'b1;
        end
        S_RESP: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (op_r == OP_DUMP && !last) begin
              idx <= idx + 1'b1;
              state <= S_DUMP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign link_up = (op_r == OP_DUMP) ? 1'b0 : up_r;
  assign links_down = (op_r == OP_DUMP) ? 5'd0 : 5'(down_cnt);
endmodule
`default_nettype wire
